// ----- rtl/sdd_pkg.sv -----
// Shared types, codes and constants of the step detector with distance estimate.
package sdd_pkg;

  // Field and port widths
  localparam int LEVEL_W    = 24;
  localparam int MAG_W      = 16;
  localparam int TIME_W     = 32;
  localparam int DIST_W     = 32;
  localparam int TOTAL_W    = 24;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Filter coefficients, 20 fraction bits
  localparam int COEF_FRAC  = 20;
  localparam int CB0        = 8200;
  localparam int NEG_CA1    = 1818992;
  localparam int CA2        = 803217;
  localparam int ONE_G_IN   = 2048;
  localparam int ACC_W      = 48;
  localparam int FF_SUM_W   = 20;
  localparam int FF_W       = 34;
  localparam int LVL_MAX    = 8388607;
  localparam int LVL_MIN    = -8388608;

  // Queue between classifier and step counter
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 3'd0,
    CFG_MIN_STEP_MS    = 3'd1,
    CFG_MAX_STEP_MS    = 3'd2,
    CFG_RUN_STEP_MS    = 3'd3,
    CFG_RUN_PEAK_LEVEL = 3'd4,
    CFG_MIN_SWING      = 3'd5,
    CFG_WALK_STRIDE_CM = 3'd6,
    CFG_RUN_STRIDE_CM  = 3'd7
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [6:0]  WINDOW_LENGTH_RST  = 7'd100;
  localparam logic [15:0] MIN_STEP_MS_RST    = 16'd300;
  localparam logic [15:0] MAX_STEP_MS_RST    = 16'd1500;
  localparam logic [15:0] RUN_STEP_MS_RST    = 16'd450;
  localparam logic [22:0] RUN_PEAK_LEVEL_RST = 23'd524288;
  localparam logic [22:0] MIN_SWING_RST      = 23'd65536;
  localparam logic [7:0]  WALK_STRIDE_RST    = 8'd72;
  localparam logic [7:0]  RUN_STRIDE_RST     = 8'd99;

  // Motion codes
  typedef enum logic [1:0] {
    MOTION_STATIC = 2'd0,
    MOTION_WALK   = 2'd1,
    MOTION_RUN    = 2'd2
  } motion_t;

  typedef struct packed {
    logic [6:0]  window_length;
    logic [15:0] min_step_ms;
    logic [15:0] max_step_ms;
    logic [15:0] run_step_ms;
    logic [22:0] run_peak_level;
    logic [22:0] min_swing;
    logic [7:0]  walk_stride_cm;
    logic [7:0]  run_stride_cm;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic                      peak;
    logic                      qual;
    logic                      run;
    logic                      clear;
    logic signed [LEVEL_W-1:0] filt;
  } rec_t;

  // Result word fields
  typedef struct packed {
    logic                      credited;
    logic [1:0]                added;
    logic [TOTAL_W-1:0]        total;
    logic [DIST_W-1:0]         distance;
    motion_t                   motion;
    logic signed [LEVEL_W-1:0] filt;
  } res_t;

endpackage

// ----- rtl/sdd_front.sv -----
// Front end: low-pass filter, max/min window, peak and gap classification.
module sdd_front #(
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sdd_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [sdd_pkg::MAG_W-1:0]  magnitude,
  input  logic [sdd_pkg::TIME_W-1:0] time_ms,
  input  logic                     clear_totals,
  input  logic                     q_full,
  output logic                     push,
  output sdd_pkg::rec_t            rec
);

  localparam int LW       = sdd_pkg::LEVEL_W;
  localparam int AW       = sdd_pkg::ACC_W;
  localparam int XS_SH    = LEVEL_FRAC_BITS - 11;
  localparam int HG_RAW   = 100 * (1 << LEVEL_FRAC_BITS);
  localparam int HG_INT   = (HG_RAW > sdd_pkg::LVL_MAX) ? sdd_pkg::LVL_MAX : HG_RAW;
  localparam logic signed [LW-1:0] HG_POS  = LW'(HG_INT);
  localparam logic signed [LW-1:0] HG_NEG  = -HG_POS;
  localparam logic signed [LW-1:0] THR_RST = LW'(1 << LEVEL_FRAC_BITS);
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1 << (sdd_pkg::COEF_FRAC - 1));

  // Handshake
  logic a_valid_r, a_valid_nxt, b_valid_r, b_valid_nxt;
  logic in_acc, a_move, b_ready;

  // Stage A: feed-forward part
  logic signed [16:0]                  dyn;
  logic signed [16:0]                  x1_r, x2_r;
  logic signed [sdd_pkg::FF_SUM_W-1:0] ff_sum;
  logic signed [sdd_pkg::FF_W-1:0]     ff_nxt, a_ff_r;
  logic [sdd_pkg::TIME_W-1:0]          a_time_r;
  logic                                a_clear_r;

  // Stage B: feedback part
  logic signed [LW-1:0] y1_r, y2_r, filt_nxt;
  logic signed [AW-1:0] a2y2_r, a2y2_nxt, acc, acc_sh;
  logic signed [LW-1:0] b_filt_r, b_y1_r, b_y2_r;
  logic [sdd_pkg::TIME_W-1:0] b_time_r;
  logic                 b_clear_r;

  // Stage C: window and peak classification
  logic signed [LW-1:0] hi_r, lo_r, thr_r, hi_u, lo_u, thr_calc, thr_new;
  logic [LW-1:0]        swing_r, swing_calc, swing_new;
  logic [6:0]           cnt_r, cnt_inc;
  logic signed [LW:0]   hl_sum;
  logic                 win_end, swing_ok, peak;
  logic [sdd_pkg::TIME_W-1:0] last_r, gap;

  // Pipeline control
  assign b_ready  = !b_valid_r || !q_full;
  assign push     = b_valid_r && !q_full;
  assign a_move   = a_valid_r && b_ready;
  assign in_ready = !a_valid_r || b_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (a_move) begin
      b_valid_nxt = 1'b1;
    end else if (push) begin
      b_valid_nxt = 1'b0;
    end
  end

  // Remove one g and form the numerator taps
  always_comb begin
    dyn    = $signed({1'b0, magnitude}) - 17'sd2048;
    ff_sum = sdd_pkg::FF_SUM_W'(dyn) + (sdd_pkg::FF_SUM_W'(x1_r) <<< 1)
             + sdd_pkg::FF_SUM_W'(x2_r);
    ff_nxt = sdd_pkg::FF_W'(ff_sum) * sdd_pkg::FF_W'(sdd_pkg::CB0);
  end

  // Close the feedback loop, round and saturate
  always_comb begin
    acc = (AW'(a_ff_r) <<< XS_SH) + AW'(y1_r) * AW'(sdd_pkg::NEG_CA1) - a2y2_r
          + ROUND_HALF;
    acc_sh = acc >>> sdd_pkg::COEF_FRAC;
    if (acc_sh > AW'(sdd_pkg::LVL_MAX)) begin
      filt_nxt = LW'(sdd_pkg::LVL_MAX);
    end else if (acc_sh < AW'(sdd_pkg::LVL_MIN)) begin
      filt_nxt = LW'(sdd_pkg::LVL_MIN);
    end else begin
      filt_nxt = LW'(acc_sh);
    end
    a2y2_nxt = AW'(y1_r) * AW'(sdd_pkg::CA2);
  end

  // Track window extremes, then test for a peak and its gap
  always_comb begin
    hi_u       = (b_filt_r > hi_r) ? b_filt_r : hi_r;
    lo_u       = (b_filt_r < lo_r) ? b_filt_r : lo_r;
    cnt_inc    = cnt_r + 7'd1;
    win_end    = cnt_inc >= cfg.window_length;
    hl_sum     = (LW+1)'(hi_u) + (LW+1)'(lo_u);
    thr_calc   = LW'(hl_sum >>> 1);
    swing_calc = LW'((LW+1)'(hi_u) - (LW+1)'(lo_u));
    thr_new    = win_end ? thr_calc : thr_r;
    swing_new  = win_end ? swing_calc : swing_r;
    swing_ok   = swing_new > {1'b0, cfg.min_swing};
    peak       = (b_y1_r > b_filt_r) && (b_y1_r > b_y2_r) && (b_y1_r > thr_new) && swing_ok;
    gap        = b_time_r - last_r;
    rec.peak   = peak;
    rec.qual   = (gap > 32'(cfg.min_step_ms)) && (gap < 32'(cfg.max_step_ms));
    rec.run    = (gap < 32'(cfg.run_step_ms)) ||
                 (b_y1_r > $signed({1'b0, cfg.run_peak_level}));
    rec.clear  = b_clear_r;
    rec.filt   = b_filt_r;
  end

  // Control and filter/window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      x1_r      <= '0;
      x2_r      <= '0;
      y1_r      <= '0;
      y2_r      <= '0;
      a2y2_r    <= '0;
      hi_r      <= HG_NEG;
      lo_r      <= HG_POS;
      cnt_r     <= '0;
      thr_r     <= THR_RST;
      swing_r   <= '0;
      last_r    <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      if (in_acc) begin
        x2_r <= x1_r;
        x1_r <= dyn;
      end
      if (a_move) begin
        y2_r   <= y1_r;
        y1_r   <= filt_nxt;
        a2y2_r <= a2y2_nxt;
      end
      if (push) begin
        hi_r    <= win_end ? HG_NEG : hi_u;
        lo_r    <= win_end ? HG_POS : lo_u;
        cnt_r   <= win_end ? 7'd0 : cnt_inc;
        thr_r   <= thr_new;
        swing_r <= swing_new;
        if (peak) begin
          last_r <= b_time_r;
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_ff_r    <= ff_nxt;
      a_time_r  <= time_ms;
      a_clear_r <= clear_totals;
    end
    if (a_move) begin
      b_filt_r  <= filt_nxt;
      b_y1_r    <= y1_r;
      b_y2_r    <= y2_r;
      b_time_r  <= a_time_r;
      b_clear_r <= a_clear_r;
    end
  end

endmodule

// ----- rtl/sdd_queue.sv -----
// Short queue of classified samples between front end and step counter.
module sdd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sdd_pkg::rec_t push_rec,
  input  logic          pop,
  output sdd_pkg::rec_t head,
  output logic          full,
  output logic          empty
);

  localparam logic [sdd_pkg::QCNT_W-1:0] CNT_DEPTH = sdd_pkg::QCNT_W'(sdd_pkg::QDEPTH);

  sdd_pkg::rec_t               mem_r [sdd_pkg::QDEPTH];
  logic [sdd_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [sdd_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = cnt_r == CNT_DEPTH;
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  // Count follows push and pop
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_DEPTH)
    else $error("queue count above depth");

  a_cnt_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not drop on pop");
`endif

endmodule

// ----- rtl/sdd_back.sv -----
// Back end: step run tracking, saturating totals and the result register.
module sdd_back #(
  parameter int STEP_COUNT_WIDTH = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sdd_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  sdd_pkg::rec_t q_head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output sdd_pkg::res_t res
);

  localparam int SW = STEP_COUNT_WIDTH;
  localparam logic [SW:0] STEP_MAX = {1'b0, {SW{1'b1}}};

  logic                     ov_r;
  sdd_pkg::res_t            res_r, res_nxt;
  logic [1:0]               rl_r, rl_nxt;
  logic [SW-1:0]            steps_r, steps_base, steps_nxt;
  logic [sdd_pkg::DIST_W-1:0] dist_r, dist_base, dist_nxt;
  sdd_pkg::motion_t         motion_r, motion_nxt;
  logic [1:0]               added;
  logic [7:0]               stride;
  logic [9:0]               dist_inc;
  logic [SW:0]              s_sum;
  logic [sdd_pkg::DIST_W:0] d_sum;

  assign pop       = !q_empty && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign res       = res_r;

  // Credit steps for a qualified peak; an unqualified peak restarts the run
  always_comb begin
    steps_base = q_head.clear ? '0 : steps_r;
    dist_base  = q_head.clear ? '0 : dist_r;
    added      = 2'd0;
    rl_nxt     = rl_r;
    motion_nxt = motion_r;
    if (q_head.peak) begin
      if (q_head.qual) begin
        case (rl_r)
          2'd3: begin
            added = 2'd1;
          end
          2'd2: begin
            added  = 2'd3;
            rl_nxt = 2'd3;
          end
          default: begin
            rl_nxt = rl_r + 2'd1;
          end
        endcase
        if (added != 2'd0) begin
          motion_nxt = q_head.run ? sdd_pkg::MOTION_RUN : sdd_pkg::MOTION_WALK;
        end
      end else begin
        rl_nxt     = 2'd1;
        motion_nxt = sdd_pkg::MOTION_STATIC;
      end
    end
    stride    = q_head.run ? cfg.run_stride_cm : cfg.walk_stride_cm;
    dist_inc  = 10'(stride) * 10'(added);
    s_sum     = (SW+1)'(steps_base) + (SW+1)'(added);
    steps_nxt = (s_sum > STEP_MAX) ? STEP_MAX[SW-1:0] : s_sum[SW-1:0];
    d_sum     = (sdd_pkg::DIST_W+1)'(dist_base) + (sdd_pkg::DIST_W+1)'(dist_inc);
    dist_nxt  = d_sum[sdd_pkg::DIST_W] ? '1 : d_sum[sdd_pkg::DIST_W-1:0];

    res_nxt.credited = added != 2'd0;
    res_nxt.added    = added;
    res_nxt.total    = sdd_pkg::TOTAL_W'(steps_nxt);
    res_nxt.distance = dist_nxt;
    res_nxt.motion   = motion_nxt;
    res_nxt.filt     = q_head.filt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      rl_r     <= 2'd0;
      steps_r  <= '0;
      dist_r   <= '0;
      motion_r <= sdd_pkg::MOTION_STATIC;
    end else begin
      if (pop) begin
        ov_r     <= 1'b1;
        rl_r     <= rl_nxt;
        steps_r  <= steps_nxt;
        dist_r   <= dist_nxt;
        motion_r <= motion_nxt;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_run_third: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_head.peak && q_head.qual && rl_r == 2'd2) |=> (rl_r == 2'd3))
    else $error("third qualified step did not complete the run");

  a_motion_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(motion_r))
    else $error("motion changed without a sample");
`endif

endmodule

// ----- rtl/step_detector_distance.sv -----
// Top level of the peak-based step detector with distance estimate.
//
// Takes one acceleration magnitude word per clock and returns one result word per input
// word, in order. Throughput is one word per cycle. A result is valid once its input word
// is accepted and has passed the numerator-tap register, the feedback filter register with
// its round and saturate, and one slot of the four-entry queue, and has then been loaded
// into the result register. The second-order feedback of the filter closes directly around
// its own state registers, so that loop sets the rate. Either side may stall independently;
// the queue absorbs short stalls of the result side. Configuration writes take effect on
// the next clock edge and are meant to happen only while no word is in flight.
module step_detector_distance #(
  parameter int LEVEL_FRAC_BITS  = 16,
  parameter int STEP_COUNT_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: magnitude[15:0], time_ms[47:16], clear_totals[48], zero[55:49]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sdd_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: step_credited[0], steps_added[2:1], step_total[26:3],
  //            distance_cm[58:27], motion_state[60:59], filtered_level[84:61], zero[87:85]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sdd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [sdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sdd_pkg::cfg_t cfg_r;
  sdd_pkg::rec_t push_rec, q_head;
  sdd_pkg::res_t res;
  logic          push, pop, q_full, q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length  <= sdd_pkg::WINDOW_LENGTH_RST;
      cfg_r.min_step_ms    <= sdd_pkg::MIN_STEP_MS_RST;
      cfg_r.max_step_ms    <= sdd_pkg::MAX_STEP_MS_RST;
      cfg_r.run_step_ms    <= sdd_pkg::RUN_STEP_MS_RST;
      cfg_r.run_peak_level <= sdd_pkg::RUN_PEAK_LEVEL_RST;
      cfg_r.min_swing      <= sdd_pkg::MIN_SWING_RST;
      cfg_r.walk_stride_cm <= sdd_pkg::WALK_STRIDE_RST;
      cfg_r.run_stride_cm  <= sdd_pkg::RUN_STRIDE_RST;
    end else if (cfg_we) begin
      case (sdd_pkg::cfg_idx_t'(cfg_index))
        sdd_pkg::CFG_WINDOW_LENGTH:  cfg_r.window_length  <= cfg_data[6:0];
        sdd_pkg::CFG_MIN_STEP_MS:    cfg_r.min_step_ms    <= cfg_data[15:0];
        sdd_pkg::CFG_MAX_STEP_MS:    cfg_r.max_step_ms    <= cfg_data[15:0];
        sdd_pkg::CFG_RUN_STEP_MS:    cfg_r.run_step_ms    <= cfg_data[15:0];
        sdd_pkg::CFG_RUN_PEAK_LEVEL: cfg_r.run_peak_level <= cfg_data[22:0];
        sdd_pkg::CFG_MIN_SWING:      cfg_r.min_swing      <= cfg_data[22:0];
        sdd_pkg::CFG_WALK_STRIDE_CM: cfg_r.walk_stride_cm <= cfg_data[7:0];
        sdd_pkg::CFG_RUN_STRIDE_CM:  cfg_r.run_stride_cm  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  sdd_front #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .magnitude    (in_tdata[15:0]),
    .time_ms      (in_tdata[47:16]),
    .clear_totals (in_tdata[48]),
    .q_full       (q_full),
    .push         (push),
    .rec          (push_rec)
  );

  sdd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sdd_back #(
    .STEP_COUNT_WIDTH(STEP_COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // Pack the result word, first field lowest
  assign out_tdata = {3'b000, res.filt, res.motion, res.distance, res.total,
                      res.added, res.credited};

endmodule

// ----- dv/step_detector_distance_tb.sv -----
// Self-checking testbench for the peak-based step detector with distance estimate.
`timescale 1ns / 100ps

// One expected or observed result word, split into its fields
typedef struct {
  logic                               credited;
  logic [1:0]                         added;
  logic [sdd_pkg::TOTAL_W-1:0]        total;
  logic [sdd_pkg::DIST_W-1:0]         distance;
  sdd_pkg::motion_t                   motion;
  logic signed [sdd_pkg::LEVEL_W-1:0] level;
} step_result_t;

// Tracks filter, window and step state and checks each result word in order
class pedometer_scoreboard;
  localparam longint B_OUTER      = 8200;
  localparam longint B_MIDDLE     = 16400;
  localparam longint A_ONE        = 1818992;
  localparam longint A_TWO        = 803217;
  localparam longint INPUT_SCALE  = 32;
  localparam longint ROUND_HALF   = 524288;
  localparam int     COEF_SHIFT   = 20;
  localparam longint LEVEL_TOP    = 8388607;
  localparam longint LEVEL_BOTTOM = -8388608;
  localparam longint HUNDRED_G    = 6553600;
  localparam longint ONE_G_LEVEL  = 65536;
  localparam longint STEP_TOP     = 64'hFF_FFFF;
  localparam longint DIST_TOP     = 64'hFFFF_FFFF;

  // Register copies
  logic [6:0]  window_length;
  logic [15:0] min_step_ms, max_step_ms, run_step_ms;
  longint      run_peak_level, min_swing;
  logic [7:0]  walk_stride_cm, run_stride_cm;

  // Filter delays and window tracking
  longint      in_d1, in_d2, lvl_d1, lvl_d2;
  longint      win_high, win_low, threshold, swing;
  logic [6:0]  win_count;
  logic [31:0] last_peak_ms;
  int          run_len;
  longint unsigned steps_held, distance_held;
  sdd_pkg::motion_t motion_held;

  step_result_t expected_results[$];
  int errors, words_checked, credit_words, run_words, broken_peaks, window_ends;

  function new();
    window_length  = sdd_pkg::WINDOW_LENGTH_RST;
    min_step_ms    = sdd_pkg::MIN_STEP_MS_RST;
    max_step_ms    = sdd_pkg::MAX_STEP_MS_RST;
    run_step_ms    = sdd_pkg::RUN_STEP_MS_RST;
    run_peak_level = {41'd0, sdd_pkg::RUN_PEAK_LEVEL_RST};
    min_swing      = {41'd0, sdd_pkg::MIN_SWING_RST};
    walk_stride_cm = sdd_pkg::WALK_STRIDE_RST;
    run_stride_cm  = sdd_pkg::RUN_STRIDE_RST;
    in_d1 = 0; in_d2 = 0; lvl_d1 = 0; lvl_d2 = 0;
    win_high = -HUNDRED_G; win_low = HUNDRED_G;
    threshold = ONE_G_LEVEL; swing = 0;
    win_count = 0; last_peak_ms = 0; run_len = 0;
    steps_held = 0; distance_held = 0; motion_held = sdd_pkg::MOTION_STATIC;
    errors = 0; words_checked = 0; credit_words = 0; run_words = 0;
    broken_peaks = 0; window_ends = 0;
  endfunction

  function void set_register(sdd_pkg::cfg_idx_t idx, logic [sdd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      sdd_pkg::CFG_WINDOW_LENGTH:  window_length  = val[6:0];
      sdd_pkg::CFG_MIN_STEP_MS:    min_step_ms    = val[15:0];
      sdd_pkg::CFG_MAX_STEP_MS:    max_step_ms    = val[15:0];
      sdd_pkg::CFG_RUN_STEP_MS:    run_step_ms    = val[15:0];
      sdd_pkg::CFG_RUN_PEAK_LEVEL: run_peak_level = {41'd0, val};
      sdd_pkg::CFG_MIN_SWING:      min_swing      = {41'd0, val};
      sdd_pkg::CFG_WALK_STRIDE_CM: walk_stride_cm = val[7:0];
      sdd_pkg::CFG_RUN_STRIDE_CM:  run_stride_cm  = val[7:0];
      default: ;
    endcase
  endfunction

  // Advance the state by one accepted sample and queue the result it causes
  function void note_sample(logic [sdd_pkg::IN_DATA_W-1:0] word);
    logic [15:0]      mag;
    logic [31:0]      stamp;
    logic             clr;
    longint           dyn, acc, lvl;
    logic [31:0]      gap;
    int               added;
    sdd_pkg::motion_t mode;
    longint unsigned  stride, sum_steps, sum_dist;
    step_result_t     want;
    mag   = word[15:0];
    stamp = word[47:16];
    clr   = word[48];
    added = 0;
    if (clr) begin
      steps_held    = 0;
      distance_held = 0;
    end

    // Remove one g, filter, round half up and saturate
    dyn = {48'd0, mag};
    dyn = dyn - sdd_pkg::ONE_G_IN;
    acc = (B_OUTER * dyn + B_MIDDLE * in_d1 + B_OUTER * in_d2) * INPUT_SCALE
          + A_ONE * lvl_d1 - A_TWO * lvl_d2;
    lvl = (acc + ROUND_HALF) >>> COEF_SHIFT;
    if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
    else if (lvl < LEVEL_BOTTOM) lvl = LEVEL_BOTTOM;

    // Track the window extremes and close the window at its length
    if (lvl > win_high) win_high = lvl;
    if (lvl < win_low) win_low = lvl;
    win_count = win_count + 7'd1;
    if (win_count >= window_length) begin
      threshold = (win_high + win_low) >>> 1;
      swing     = win_high - win_low;
      win_high  = -HUNDRED_G;
      win_low   = HUNDRED_G;
      win_count = 0;
      window_ends++;
    end

    // Qualify a peak on the previous level by the gap since the last one
    if (lvl_d1 > lvl && lvl_d1 > lvl_d2 && lvl_d1 > threshold && swing > min_swing) begin
      gap = stamp - last_peak_ms;
      last_peak_ms = stamp;
      if (gap > min_step_ms && gap < max_step_ms) begin
        mode = (gap < run_step_ms || lvl_d1 > run_peak_level) ?
               sdd_pkg::MOTION_RUN : sdd_pkg::MOTION_WALK;
        if (run_len == 3) begin
          added = 1;
        end else if (run_len == 2) begin
          run_len = 3;
          added   = 3;
        end else begin
          run_len++;
        end
        if (added != 0) begin
          stride        = (mode == sdd_pkg::MOTION_RUN) ? run_stride_cm : walk_stride_cm;
          sum_steps     = steps_held + added;
          sum_dist      = distance_held + stride * added;
          steps_held    = (sum_steps > STEP_TOP) ? STEP_TOP : sum_steps;
          distance_held = (sum_dist > DIST_TOP) ? DIST_TOP : sum_dist;
          motion_held   = mode;
          credit_words++;
          if (mode == sdd_pkg::MOTION_RUN) run_words++;
        end
      end else begin
        run_len     = 1;
        motion_held = sdd_pkg::MOTION_STATIC;
        broken_peaks++;
      end
    end

    in_d2  = in_d1;
    in_d1  = dyn;
    lvl_d2 = lvl_d1;
    lvl_d1 = lvl;

    want.credited = (added != 0);
    want.added    = added[1:0];
    want.total    = steps_held[sdd_pkg::TOTAL_W-1:0];
    want.distance = distance_held[sdd_pkg::DIST_W-1:0];
    want.motion   = motion_held;
    want.level    = lvl[sdd_pkg::LEVEL_W-1:0];
    expected_results.push_back(want);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Compare one result word with the oldest expectation
  function void check_result(logic [sdd_pkg::OUT_DATA_W-1:0] word);
    step_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result word %0h with no sample pending", $time, word);
      return;
    end
    want = expected_results.pop_front();
    words_checked++;
    compare_field("step_credited", {31'd0, want.credited}, {31'd0, word[0]});
    compare_field("steps_added", {30'd0, want.added}, {30'd0, word[2:1]});
    compare_field("step_total", {8'd0, want.total}, {8'd0, word[26:3]});
    compare_field("distance_cm", want.distance, word[58:27]);
    compare_field("motion_state", {30'd0, want.motion}, {30'd0, word[60:59]});
    compare_field("filtered_level", {8'd0, want.level}, {8'd0, word[84:61]});
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function int final_errors();
    if (expected_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    return errors + expected_results.size();
  endfunction
endclass

module step_detector_distance_tb;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // magnitude[15:0], time_ms[47:16], clear_totals[48], zero[55:49]
  logic [sdd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // step_credited[0], steps_added[2:1], step_total[26:3], distance_cm[58:27],
  // motion_state[60:59], filtered_level[84:61], zero[87:85]
  logic [sdd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we = 1'b0;
  logic [sdd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sdd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                           steady_flow = 1'b0;
  logic                           hold_request = 1'b0;
  logic [31:0]                    clock_ms = 32'd0;
  pedometer_scoreboard            sb;

  step_detector_distance DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Record each accepted sample word and check each accepted result word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: random stalls, one long hold-off on request, steady stretches
  initial begin : receiver
    int  hold_left;
    bit  held_once;
    hold_left = 0;
    held_once = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !held_once) begin
        hold_left = HOLD_CYCLES;
        held_once = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady_flow) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // End the run when no word moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one sample word, idling first at random, and hold it until taken
  task automatic send_word(input logic [15:0] mag, input logic [31:0] stamp,
                           input logic clr);
    while (!steady_flow && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, clr, stamp, mag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input sdd_pkg::cfg_idx_t idx,
                           input logic [sdd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(input int wl, input int min_ms, input int max_ms,
                                input int run_ms, input int peak_lvl, input int swing_min,
                                input int walk_cm, input int run_cm);
    write_reg(sdd_pkg::CFG_WINDOW_LENGTH, sdd_pkg::CFG_DATA_W'(wl));
    write_reg(sdd_pkg::CFG_MIN_STEP_MS, sdd_pkg::CFG_DATA_W'(min_ms));
    write_reg(sdd_pkg::CFG_MAX_STEP_MS, sdd_pkg::CFG_DATA_W'(max_ms));
    write_reg(sdd_pkg::CFG_RUN_STEP_MS, sdd_pkg::CFG_DATA_W'(run_ms));
    write_reg(sdd_pkg::CFG_RUN_PEAK_LEVEL, sdd_pkg::CFG_DATA_W'(peak_lvl));
    write_reg(sdd_pkg::CFG_MIN_SWING, sdd_pkg::CFG_DATA_W'(swing_min));
    write_reg(sdd_pkg::CFG_WALK_STRIDE_CM, sdd_pkg::CFG_DATA_W'(walk_cm));
    write_reg(sdd_pkg::CFG_RUN_STRIDE_CM, sdd_pkg::CFG_DATA_W'(run_cm));
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Field extremes, timestamp wrap, clears and one filtered pulse
  task automatic run_directed();
    int k;
    send_word(16'h0000, 32'd0, 1'b0);
    send_word(16'hFFFF, 32'd20, 1'b0);
    send_word(16'h0800, 32'd40, 1'b1);
    send_word(16'h07FF, 32'd60, 1'b0);
    send_word(16'h0801, 32'hFFFF_FFF0, 1'b0);
    send_word(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(16'h0000, 32'h0000_0000, 1'b0);
    send_word(16'h8000, 32'h0000_0100, 1'b0);
    for (k = 0; k < 14; k++) begin
      clock_ms += 32'd100;
      send_word((k < 7) ? 16'd40000 : 16'd0, clock_ms, 1'b0);
    end
  endtask

  // Square-wave gait bursts with random pace, swing and offset, plus noise bursts
  task automatic drive_gait(input int count);
    int sent, half, amp, base, noise, dt, span, k, val;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        span = $urandom_range(3, 12);
        for (k = 0; k < span && sent < count; k++) begin
          if ($urandom_range(3) == 0) clock_ms = $urandom();
          else clock_ms += $urandom_range(0, 3000);
          send_word(16'($urandom_range(65535)), clock_ms, $urandom_range(3) == 0);
          sent++;
        end
      end else begin
        half  = $urandom_range(6, 30);
        amp   = $urandom_range(600, 30000);
        base  = $urandom_range(0, 8192);
        noise = $urandom_range(0, 300);
        dt    = $urandom_range(4, 45);
        span  = 2 * half * $urandom_range(2, 6);
        for (k = 0; k < span && sent < count; k++) begin
          val = base + ((((k / half) % 2) == 0) ? amp : -amp) + $urandom_range(0, noise);
          if (val < 0) val = 0;
          if (val > 65535) val = 65535;
          clock_ms += dt + $urandom_range(0, 2);
          send_word(val[15:0], clock_ms, $urandom_range(199) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int total_errors;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings
    run_directed();
    drive_gait(150);
    drain_results();

    // Typical settings, no idling on either side
    steady_flow <= 1'b1;
    apply_settings(20, 200, 1200, 400, 300000, 20000, 72, 99);
    drive_gait(250);
    drain_results();
    steady_flow <= 1'b0;

    // Wide gap limits and zero thresholds, so most peaks qualify and run; timestamps wrap early on
    apply_settings(127, 0, 65535, 65535, 0, 0, 255, 255);
    clock_ms = 32'hFFFF_FF00;
    drive_gait(150);
    drain_results();

    // Swing can never pass: no peaks at all
    apply_settings(1, 65535, 65535, 0, 8388607, 8388607, 0, 0);
    drive_gait(100);
    drain_results();

    // Zero window and zero gap limits: every peak breaks the run
    apply_settings(0, 0, 0, 0, 8388607, 0, 0, 0);
    drive_gait(100);
    drain_results();

    // Long receiver hold-off while samples keep coming
    apply_settings(64, 250, 1400, 500, 400000, 1000, 1, 200);
    hold_request <= 1'b1;
    drive_gait(250);
    drain_results();

    // Random moderate settings
    apply_settings($urandom_range(8, 40), $urandom_range(100, 400), $urandom_range(800, 2000),
                   $urandom_range(200, 700), $urandom_range(100000, 900000),
                   $urandom_range(0, 100000), $urandom_range(255), $urandom_range(255));
    drive_gait(100);
    drain_results();

    total_errors = sb.final_errors();
    $display("Checked %0d result words over seven register settings:", sb.words_checked);
    $display("%0d window closes, %0d broken-gap peaks, %0d credit words, %0d of them running.",
             sb.window_ends, sb.broken_peaks, sb.credit_words, sb.run_words);
    if (total_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/sdd_pkg.sv
rtl/sdd_front.sv
rtl/sdd_queue.sv
rtl/sdd_back.sv
rtl/step_detector_distance.sv
dv/step_detector_distance_tb.sv
